>>> hdl/pn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn_pkg - shared definitions for the path normaliser
// Widths, character codes, scanner codes and the result record.
// ----------------------------------------------------------------------------
package pn_pkg;

   localparam int MAX_PATH_BYTES = 256;
   localparam int CNT_W       = $clog2(MAX_PATH_BYTES + 1);
   localparam int STACK_DEPTH = 128;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int SCNT_W      = $clog2(STACK_DEPTH + 1);
   localparam int CHAR_W      = 8;
   localparam int KEEP_W      = 8;
   localparam int LEN_W       = 9;
   localparam int MAX_OUT     = 255;

   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SLASH  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DOT1   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DOT2   = 2'd3;

   typedef struct packed {
      logic [KEEP_W-1:0] keep_length;
      logic              append_valid;
      logic [CHAR_W-1:0] append_char;
      logic              path_done;
      logic              bad_path;
   } rsp_payload_type;

endpackage
`default_nettype wire

>>> hdl/pn_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn_req_if - character channel
// One path byte per beat, with an end-of-path mark.
// ----------------------------------------------------------------------------
interface pn_req_if
   import pn_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] ch;
   logic              end_of_path;

   modport source (output valid, output ch, output end_of_path, input ready);
   modport sink   (input valid, input ch, input end_of_path, output ready);
endinterface
`default_nettype wire

>>> hdl/pn_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn_rsp_if - edit channel
// One truncate/append edit per beat.
// ----------------------------------------------------------------------------
interface pn_rsp_if
   import pn_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [KEEP_W-1:0] keep_length;
   logic              append_valid;
   logic [CHAR_W-1:0] append_char;
   logic              path_done;
   logic              bad_path;

   modport source (output valid, output keep_length, output append_valid,
                   output append_char, output path_done, output bad_path,
                   input ready);
   modport sink   (input valid, input keep_length, input append_valid,
                   input append_char, input path_done, input bad_path,
                   output ready);
endinterface
`default_nettype wire

>>> hdl/path_normalizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// path_normalizer_top - streaming absolute path canonicaliser
//
// req_chan carries one path byte per beat (ch, end_of_path on the last byte).
// rsp_chan returns exactly one edit per byte: truncate the normalised text to
// keep_length, then append append_char when append_valid is set. path_done
// echoes the end mark; bad_path flags an over-long or relative path and stays
// set until the end of that path, with no edits made meanwhile.
// The edit for a byte is formed combinationally and registered in the output buffer before it is presented.
// Throughput: one byte per cycle while the output buffer has room; the slash
// stack lives in one RAM with one write and one registered read port, and a
// pop refills the cached second entry from that port in the following cycle.
// Reset: synchronous; scanner, lengths and stack count clear at once, no
// sweep of the stack RAM is needed. The state also clears after every path.
// Stall: a two-entry output buffer absorbs a stalled receiver; req_chan.ready
// drops only when both entries are full.
// ----------------------------------------------------------------------------
module path_normalizer_top
   import pn_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   pn_req_if.sink    req_chan,
   pn_rsp_if.source  rsp_chan
);

   logic                res_valid;
   logic                res_ready;
   rsp_payload_type     res_data;
   logic                ram_wr_en;
   logic [STACK_AW-1:0] ram_wr_addr;
   logic [CHAR_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [STACK_AW-1:0] ram_rd_addr;
   logic [CHAR_W-1:0]   ram_rd_data;

   pn_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   pn_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pn_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_ready (res_ready),
      .in_data  (res_data),
      .rsp      (rsp_chan)
   );

endmodule
`default_nettype wire

>>> hdl/pn_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> hdl/pn_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn_scan - path scanner and slash stack control
// Turns each byte into one edit; keeps the stack top and the entry below it
// in registers and refills the lower one from the stack RAM after a pop.
// ----------------------------------------------------------------------------
module pn_scan
   import pn_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   pn_req_if.sink                   req,
   output      logic                res_valid,
   input  wire logic                res_ready,
   output      rsp_payload_type     res_data,
   output      logic                ram_wr_en,
   output      logic [STACK_AW-1:0] ram_wr_addr,
   output      logic [CHAR_W-1:0]   ram_wr_data,
   output      logic                ram_rd_en,
   output      logic [STACK_AW-1:0] ram_rd_addr,
   input  wire logic [CHAR_W-1:0]   ram_rd_data
);

   logic [MODE_W-1:0] mode_ff,    mode_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic [CNT_W-1:0]  in_cnt_ff,  in_cnt_in;
   logic [SCNT_W-1:0] scnt_ff,    scnt_in;
   logic              err_ff,     err_in;
   logic              pend_ff,    pend_in;
   logic [CHAR_W-1:0] top_ff,     top_in;
   logic [CHAR_W-1:0] below_ff,   below_in;

   logic              accept;
   logic              is_slash;
   logic              is_dot;
   logic              grows;
   logic              err_now;
   logic              push;
   logic              pop;
   logic              refill;
   logic [LEN_W-1:0]  keep;
   logic              app;
   logic [MODE_W-1:0] mode_n;
   logic [SCNT_W-1:0] scnt_n;
   logic [CHAR_W-1:0] top_n;
   logic [CHAR_W-1:0] below_n;
   logic [CHAR_W-1:0] cur_top;
   logic [LEN_W-1:0]  len_n;
   logic [LEN_W-1:0]  fin;
   logic [SCNT_W-1:0] rd_addr_full;

   assign accept    = req.valid && res_ready;
   assign req.ready = res_ready;
   assign res_valid = req.valid;

   assign is_slash = (req.ch == CHAR_SLASH);
   assign is_dot   = (req.ch == CHAR_DOT);
   assign grows    = !is_slash || (mode_ff == MODE_NORMAL);

   always_comb begin
      err_now = err_ff;
      if (!err_ff) begin
         if (({1'b0, in_cnt_ff} + 1'b1) >= (CNT_W + 1)'(MAX_PATH_BYTES)) begin
            err_now = 1'b1;
         end else if ((in_cnt_ff == '0) && !is_slash) begin
            err_now = 1'b1;
         end else if (grows && (out_len_ff >= LEN_W'(MAX_OUT))) begin
            err_now = 1'b1;
         end else if (is_slash && (mode_ff == MODE_NORMAL) &&
                      (scnt_ff >= SCNT_W'(STACK_DEPTH))) begin
            err_now = 1'b1;
         end
      end
   end

   // one edit per byte; the final byte may shorten it to the last slash
   always_comb begin
      keep    = out_len_ff;
      app     = 1'b0;
      mode_n  = mode_ff;
      scnt_n  = scnt_ff;
      top_n   = top_ff;
      below_n = pend_ff ? ram_rd_data : below_ff;
      push    = 1'b0;
      pop     = 1'b0;
      refill  = 1'b0;
      len_n   = out_len_ff;
      fin     = out_len_ff;
      cur_top = '0;
      if (!err_now) begin
         if (is_slash) begin
            case (mode_ff)
               MODE_NORMAL: begin
                  push    = 1'b1;
                  app     = 1'b1;
                  top_n   = out_len_ff[CHAR_W-1:0];
                  below_n = top_ff;
                  scnt_n  = scnt_ff + 1'b1;
               end
               MODE_DOT1: begin
                  keep = out_len_ff - LEN_W'(1);
               end
               MODE_DOT2: begin
                  if (scnt_ff >= SCNT_W'(2)) begin
                     pop    = 1'b1;
                     refill = (scnt_ff >= SCNT_W'(3));
                     scnt_n = scnt_ff - 1'b1;
                     top_n  = below_n;
                  end
                  cur_top = (scnt_n == '0) ? '0 : top_n;
                  keep    = {1'b0, cur_top} + LEN_W'(1);
               end
               default: begin
               end
            endcase
            mode_n = MODE_SLASH;
         end else begin
            app = 1'b1;
            if (is_dot && (mode_ff == MODE_SLASH)) begin
               mode_n = MODE_DOT1;
            end else if (is_dot && (mode_ff == MODE_DOT1)) begin
               mode_n = MODE_DOT2;
            end else begin
               mode_n = MODE_NORMAL;
            end
         end
         len_n = keep + {{(LEN_W-1){1'b0}}, app};
         if (req.end_of_path) begin
            if (mode_n == MODE_NORMAL) begin
               fin = len_n;
            end else if ((mode_n == MODE_DOT2) && (scnt_n >= SCNT_W'(2))) begin
               fin = {1'b0, below_n};
            end else if (scnt_n == '0) begin
               fin = '0;
            end else begin
               fin = {1'b0, top_n};
            end
            if (fin < len_n) begin
               keep = fin;
               app  = 1'b0;
            end
         end
      end
   end

   always_comb begin
      res_data.keep_length  = keep[KEEP_W-1:0];
      res_data.append_valid = app;
      res_data.append_char  = app ? req.ch : CHAR_NUL;
      res_data.path_done    = req.end_of_path;
      res_data.bad_path     = err_now;
   end

   assign rd_addr_full = scnt_ff - SCNT_W'(3);
   assign ram_wr_en    = accept && push;
   assign ram_wr_addr  = scnt_ff[STACK_AW-1:0];
   assign ram_wr_data  = out_len_ff[CHAR_W-1:0];
   assign ram_rd_en    = accept && refill && !req.end_of_path;
   assign ram_rd_addr  = rd_addr_full[STACK_AW-1:0];

   always_comb begin
      mode_in    = mode_ff;
      out_len_in = out_len_ff;
      in_cnt_in  = in_cnt_ff;
      scnt_in    = scnt_ff;
      err_in     = err_ff;
      top_in     = top_ff;
      below_in   = pend_ff ? ram_rd_data : below_ff;
      pend_in    = ram_rd_en;
      if (accept) begin
         if (req.end_of_path) begin
            mode_in    = MODE_NORMAL;
            out_len_in = '0;
            in_cnt_in  = '0;
            scnt_in    = '0;
            err_in     = 1'b0;
         end else begin
            mode_in    = mode_n;
            out_len_in = len_n;
            scnt_in    = scnt_n;
            top_in     = top_n;
            below_in   = below_n;
            err_in     = err_now;
            if (in_cnt_ff < CNT_W'(MAX_PATH_BYTES)) begin
               in_cnt_in = in_cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         out_len_ff <= '0;
         in_cnt_ff  <= '0;
         scnt_ff    <= '0;
         err_ff     <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         out_len_ff <= out_len_in;
         in_cnt_ff  <= in_cnt_in;
         scnt_ff    <= scnt_in;
         err_ff     <= err_in;
         pend_ff    <= pend_in;
      end
      top_ff   <= top_in;
      below_ff <= below_in;
   end

   // while a refill is in flight, no stack change may need it
   a_no_pop_during_refill: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !(accept && (pop || push)))
      else $error("stack changed while refill outstanding");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      scnt_ff <= SCNT_W'(STACK_DEPTH))
      else $error("slash stack overflow");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      out_len_ff <= LEN_W'(MAX_OUT))
      else $error("output length beyond limit");

   a_stack_tracks_slash: assert property (@(posedge clock) disable iff (reset)
      (accept && !req.end_of_path && !err_now && (mode_n != MODE_NORMAL))
      |=> (scnt_ff != '0))
      else $error("empty stack while inside a path");

endmodule
`default_nettype wire

>>> hdl/pn_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn_out_buf - two-entry result buffer
// Output register plus skid entry; upstream ready comes from a flop.
// ----------------------------------------------------------------------------
module pn_out_buf
   import pn_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output      logic            in_ready,
   input  wire rsp_payload_type in_data,
   pn_rsp_if.source             rsp
);

   logic            out_v_ff,  out_v_in;
   logic            skid_v_ff, skid_v_in;
   rsp_payload_type out_ff,    out_in;
   rsp_payload_type skid_ff,   skid_in;
   logic            take;
   logic            acc;

   assign take     = out_v_ff && rsp.ready;
   assign in_ready = !skid_v_ff;
   assign acc      = in_valid && in_ready;

   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_in    = out_ff;
      skid_in   = skid_ff;
      if (take) begin
         if (skid_v_ff) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end else if (acc) begin
            out_in = in_data;
         end else begin
            out_v_in = 1'b0;
         end
      end else if (acc) begin
         if (!out_v_ff) begin
            out_in   = in_data;
            out_v_in = 1'b1;
         end else begin
            skid_in   = in_data;
            skid_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.keep_length  = out_ff.keep_length;
   assign rsp.append_valid = out_ff.append_valid;
   assign rsp.append_char  = out_ff.append_char;
   assign rsp.path_done    = out_ff.path_done;
   assign rsp.bad_path     = out_ff.bad_path;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held with empty output register");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp.ready) |=> (out_v_ff && !skid_v_ff))
      else $error("skid entry not moved after beat taken");

endmodule
`default_nettype wire
